// ----- rtl/core/lucas_base2_primality_test_core_defines.svh -----
// Assertion macros shared by the Lucas test RTL.
`ifndef LUCAS_BASE2_PRIMALITY_TEST_CORE_DEFINES_SVH
`define LUCAS_BASE2_PRIMALITY_TEST_CORE_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define LPT_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");

// Assert that an antecedent implies a consequent in the next cycle.
`define LPT_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/lbpt_pkg.sv -----
// Package: widths, controller states and command/status types.
`default_nettype none
package lbpt_pkg;
  localparam int unsigned DefWidth = 31;
  localparam int unsigned CandW    = 31;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_EXP_START, ST_EXP_MUL, ST_EXP_SQR, ST_EXP_NEXT,
    ST_FERMAT_CHK, ST_TD_TEST, ST_TD_DIV, ST_TD_DIVWAIT, ST_TD_HIT, ST_TD_HITCHK,
    ST_TD_STRIP, ST_TD_STRIPWAIT, ST_TD_NEXT, ST_REST_DIV, ST_REST_CHK, ST_DONE
  } lbpt_state_e;

  typedef enum logic [1:0] {
    MM_NONE, MM_MUL, MM_SQR
  } lbpt_mm_e;

  typedef enum logic [2:0] {
    DV_NONE, DV_REST_F, DV_NM1_F, DV_NM1_REST
  } lbpt_dv_e;

  // Controller to datapath.
  typedef struct packed {
    logic     load;      // capture the candidate
    logic     exp_nm1;   // exponent := n-1, result := 1, base := 2
    logic     exp_quo;   // exponent := quotient, same init
    lbpt_mm_e mm_op;     // start modular multiply
    logic     exp_shift; // drop exponent lsb
    lbpt_dv_e dv_op;     // start divide
    logic     rest_quo;  // rest := quotient
    logic     f_init;    // f := 2
    logic     f_inc;     // f := f + 1
  } lbpt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic below_three; // n < 3
    logic is_two;
    logic even;
    logic exp_zero;
    logic exp_lsb;
    logic res_one;
    logic mm_busy;
    logic dv_busy;
    logic rem_zero;
    logic f_sq_gt;    // f > rest / f, i.e. f*f > rest
    logic rest_gt1;
  } lbpt_sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/lbpt_datapath.sv -----
// Datapath: candidate registers, shift-and-add modular multiplier, restoring divider.
`default_nettype none
`include "lucas_base2_primality_test_core_defines.svh"
module lbpt_datapath #(
  parameter int unsigned Width = lbpt_pkg::DefWidth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [Width-1:0]   cand_i,
  input  wire lbpt_pkg::lbpt_cmd_t cmd_i,
  output      lbpt_pkg::lbpt_sts_t sts_o
);
  import lbpt_pkg::*;

  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width-1:0] n_q, exp_q, res_q, base_q, rest_q, f_q;
  logic [Width:0]   mm_acc_q, mm_x_q;
  logic [Width-1:0] mm_y_q;
  logic             mm_busy_q, mm_sqr_q;
  logic [Width-1:0] dv_num_q, dv_den_q, dv_quo_q;
  logic [Width:0]   dv_rem_q;
  logic [CntW-1:0]  dv_cnt_q;
  logic             dv_busy_q;
  logic [Width-1:0] nm1;
  logic [2*Width-1:0] f_sq;

  assign nm1  = n_q - Width'(1);
  assign f_sq = {{Width{1'b0}}, f_q} * {{Width{1'b0}}, f_q};

  // Modular-multiply step values.
  logic [Width:0] acc_add, acc_nx, x_dbl, x_nx;
  assign acc_add = mm_acc_q + mm_x_q;
  assign acc_nx  = (acc_add >= {1'b0, n_q}) ? acc_add - {1'b0, n_q} : acc_add;
  assign x_dbl   = {mm_x_q[Width-1:0], 1'b0};
  assign x_nx    = (x_dbl >= {1'b0, n_q}) ? x_dbl - {1'b0, n_q} : x_dbl;

  // Divider step values.
  logic [Width:0] rem_sh;
  assign rem_sh = {dv_rem_q[Width-1:0], dv_num_q[Width-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_busy_q <= 1'b0;
      dv_busy_q <= 1'b0;
    end else begin
      if (cmd_i.mm_op != MM_NONE) begin
        mm_busy_q <= 1'b1;
      end else if (mm_busy_q && mm_y_q == '0) begin
        mm_busy_q <= 1'b0;
      end
      if (cmd_i.dv_op != DV_NONE) begin
        dv_busy_q <= 1'b1;
      end else if (dv_busy_q && dv_cnt_q == CntW'(1)) begin
        dv_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= cand_i;
    end
    if (cmd_i.exp_nm1 || cmd_i.exp_quo) begin
      exp_q  <= cmd_i.exp_nm1 ? nm1 : dv_quo_q;
      res_q  <= Width'(1);
      base_q <= Width'(2);
    end else if (cmd_i.exp_shift) begin
      exp_q <= exp_q >> 1;
    end
    // Modular multiply: acc = x * y mod n.
    if (cmd_i.mm_op != MM_NONE) begin
      mm_sqr_q <= (cmd_i.mm_op == MM_SQR);
      mm_acc_q <= '0;
      mm_x_q   <= {1'b0, base_q};
      mm_y_q   <= (cmd_i.mm_op == MM_SQR) ? base_q : res_q;
    end else if (mm_busy_q) begin
      if (mm_y_q == '0) begin
        if (mm_sqr_q) begin
          base_q <= mm_acc_q[Width-1:0];
        end else begin
          res_q <= mm_acc_q[Width-1:0];
        end
      end else begin
        if (mm_y_q[0]) begin
          mm_acc_q <= acc_nx;
        end
        mm_x_q <= x_nx;
        mm_y_q <= mm_y_q >> 1;
      end
    end
    // Restoring divide, one quotient bit per cycle.
    if (cmd_i.dv_op != DV_NONE) begin
      case (cmd_i.dv_op)
        DV_REST_F: begin
          dv_num_q <= rest_q;
          dv_den_q <= f_q;
        end
        DV_NM1_F: begin
          dv_num_q <= nm1;
          dv_den_q <= f_q;
        end
        default: begin
          dv_num_q <= nm1;
          dv_den_q <= rest_q;
        end
      endcase
      dv_rem_q <= '0;
      dv_cnt_q <= CntW'(Width);
    end else if (dv_busy_q) begin
      dv_num_q <= {dv_num_q[Width-2:0], 1'b0};
      if (rem_sh >= {1'b0, dv_den_q}) begin
        dv_rem_q <= rem_sh - {1'b0, dv_den_q};
        dv_quo_q <= {dv_quo_q[Width-2:0], 1'b1};
      end else begin
        dv_rem_q <= rem_sh;
        dv_quo_q <= {dv_quo_q[Width-2:0], 1'b0};
      end
      dv_cnt_q <= dv_cnt_q - CntW'(1);
    end
    if (cmd_i.load) begin
      rest_q <= cand_i - Width'(1);
    end else if (cmd_i.rest_quo) begin
      rest_q <= dv_quo_q;
    end
    if (cmd_i.f_init) begin
      f_q <= Width'(2);
    end else if (cmd_i.f_inc) begin
      f_q <= f_q + Width'(1);
    end
  end

  always_comb begin
    sts_o.below_three = (n_q < Width'(3));
    sts_o.is_two   = (n_q == Width'(2));
    sts_o.even     = ~n_q[0];
    sts_o.exp_zero = (exp_q == '0);
    sts_o.exp_lsb  = exp_q[0];
    sts_o.res_one  = (res_q == Width'(1));
    sts_o.mm_busy  = mm_busy_q;
    sts_o.dv_busy  = dv_busy_q;
    sts_o.rem_zero = (dv_rem_q == '0);
    sts_o.f_sq_gt  = (f_sq > {{Width{1'b0}}, rest_q});
    sts_o.rest_gt1 = (rest_q > Width'(1));
  end

  `LPT_ASSERT_IMP(a_mm_lt_n, clk_i, rst_ni, mm_busy_q, mm_x_q < {1'b0, n_q})
  `LPT_ASSERT_IMP(a_acc_lt_n, clk_i, rst_ni, mm_busy_q, mm_acc_q < {1'b0, n_q})
  `LPT_ASSERT_IMP(a_rem_lt_den, clk_i, rst_ni, dv_busy_q && dv_den_q != '0,
                  dv_rem_q < {1'b0, dv_den_q})
endmodule
`default_nettype wire

// ----- rtl/core/lbpt_ctrl.sv -----
// Controller: sequences the checks, exponentiations and trial division.
`default_nettype none
`include "lucas_base2_primality_test_core_defines.svh"
module lbpt_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire lbpt_pkg::lbpt_sts_t sts_i,
  output      lbpt_pkg::lbpt_cmd_t cmd_o,
  output      logic                busy_o,
  output      logic                done_o,
  output      logic                verdict_o
);
  import lbpt_pkg::*;

  lbpt_state_e state_q, state_d;
  logic        ret_q, ret_d;   // 0: Fermat check, 1: factor check
  logic        hitrest_q, hitrest_d;
  logic        verd_q, verd_d;
  logic        done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ret_q     <= 1'b0;
      hitrest_q <= 1'b0;
      verd_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      hitrest_q <= hitrest_d;
      verd_q    <= verd_d;
      done_q    <= done_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    hitrest_d = hitrest_q;
    verd_d    = verd_q;
    done_d    = 1'b0;
    cmd_o     = '0;
    cmd_o.mm_op = MM_NONE;
    cmd_o.dv_op = DV_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.below_three || sts_i.even) begin
          verd_d  = sts_i.is_two;
          state_d = ST_DONE;
        end else begin
          cmd_o.exp_nm1 = 1'b1;
          ret_d         = 1'b0;
          state_d       = ST_EXP_START;
        end
      end
      ST_EXP_START: begin
        if (sts_i.exp_zero) begin
          state_d = ret_q ? ST_TD_HITCHK : ST_FERMAT_CHK;
        end else if (sts_i.exp_lsb) begin
          cmd_o.mm_op = MM_MUL;
          state_d     = ST_EXP_MUL;
        end else begin
          cmd_o.mm_op = MM_SQR;
          state_d     = ST_EXP_SQR;
        end
      end
      ST_EXP_MUL: begin
        if (!sts_i.mm_busy) begin
          cmd_o.mm_op = MM_SQR;
          state_d     = ST_EXP_SQR;
        end
      end
      ST_EXP_SQR: begin
        if (!sts_i.mm_busy) begin
          cmd_o.exp_shift = 1'b1;
          state_d         = ST_EXP_START;
        end
      end
      ST_FERMAT_CHK: begin
        if (!sts_i.res_one) begin
          verd_d  = 1'b0;
          state_d = ST_DONE;
        end else begin
          cmd_o.f_init = 1'b1;
          state_d      = ST_TD_TEST;
        end
      end
      ST_TD_TEST: begin
        if (sts_i.f_sq_gt) begin
          if (sts_i.rest_gt1) begin
            cmd_o.dv_op = DV_NM1_REST;
            state_d     = ST_REST_DIV;
          end else begin
            verd_d  = 1'b1;
            state_d = ST_DONE;
          end
        end else begin
          cmd_o.dv_op = DV_REST_F;
          state_d     = ST_TD_DIV;
        end
      end
      ST_TD_DIV: begin
        if (!sts_i.dv_busy) begin
          if (sts_i.rem_zero) begin
            cmd_o.dv_op = DV_NM1_F;
            state_d     = ST_TD_HIT;
          end else begin
            state_d = ST_TD_NEXT;
          end
        end
      end
      ST_TD_HIT: begin
        if (!sts_i.dv_busy) begin
          cmd_o.exp_quo = 1'b1;
          ret_d         = 1'b1;
          hitrest_d     = 1'b0;
          state_d       = ST_EXP_START;
        end
      end
      ST_TD_HITCHK: begin
        if (sts_i.res_one) begin
          verd_d  = 1'b0;
          state_d = ST_DONE;
        end else if (hitrest_q) begin
          verd_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd_o.dv_op = DV_REST_F;
          state_d     = ST_TD_STRIP;
        end
      end
      ST_TD_STRIP: begin
        // rest was divisible by f: take the quotient, then test again.
        if (!sts_i.dv_busy) begin
          cmd_o.rest_quo = 1'b1;
          state_d        = ST_TD_STRIPWAIT;
        end
      end
      ST_TD_STRIPWAIT: begin
        cmd_o.dv_op = DV_REST_F;
        state_d     = ST_TD_DIVWAIT;
      end
      ST_TD_DIVWAIT: begin
        if (!sts_i.dv_busy) begin
          if (sts_i.rem_zero) begin
            cmd_o.rest_quo = 1'b1;
            state_d        = ST_TD_STRIPWAIT;
          end else begin
            state_d = ST_TD_NEXT;
          end
        end
      end
      ST_TD_NEXT: begin
        cmd_o.f_inc = 1'b1;
        state_d     = ST_TD_TEST;
      end
      ST_REST_DIV: begin
        if (!sts_i.dv_busy) begin
          cmd_o.exp_quo = 1'b1;
          ret_d         = 1'b1;
          hitrest_d     = 1'b1;
          state_d       = ST_EXP_START;
        end
      end
      ST_REST_CHK: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign done_o    = done_q;
  assign verdict_o = verd_q;

  `LPT_ASSERT_NEXT(a_done_to_idle, clk_i, rst_ni, state_q == ST_DONE, done_q && !busy_o)
  `LPT_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `LPT_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_q, state_q == ST_IDLE)
endmodule
`default_nettype wire

// ----- rtl/core/lucas_base2_primality_test_core.sv -----
// Top level of the base-2 Lucas primality test core.
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------
//  request   | start_i / busy_o   | candidate_i [30:0]
//  result    | valid_o (strobe)   | is_prime_o
//
// Run time: a request with n below three, or even, ends after the first check;
// otherwise each modular multiply steps through the bits of its second operand,
// each exponentiation takes up to 2*WIDTH multiplies, and trial division tries
// every f up to the square root of what is left of n-1, each through the
// restoring divider. The trial division loop dominates for large primes.
// Reset: asynchronous, active low; clears the controller and the busy flags of
// the multiply and divide units.
// Stalls: busy_o stays high from acceptance until valid_o; the receiver
// cannot stall, valid_o lasts one cycle.
`default_nettype none
module lucas_base2_primality_test_core #(
  parameter int unsigned WIDTH = lbpt_pkg::DefWidth
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [lbpt_pkg::CandW-1:0] candidate_i,
  output      logic                      busy_o,
  output      logic                      valid_o,
  output      logic                      is_prime_o
);
  import lbpt_pkg::*;

  lbpt_cmd_t cmd;
  lbpt_sts_t sts;
  logic [WIDTH-1:0] cand_masked;

  // Keep only the low WIDTH bits of the candidate.
  always_comb begin
    cand_masked = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (i < CandW) begin
        cand_masked[i] = candidate_i[i];
      end
    end
  end

  lbpt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (valid_o),
    .verdict_o(is_prime_o)
  );

  lbpt_datapath #(.Width(WIDTH)) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cand_i(cand_masked),
    .cmd_i (cmd),
    .sts_o (sts)
  );
endmodule
`default_nettype wire
